FILE: rtl/pwq_pkg.sv
package pwq_pkg;

    localparam int ACTION_W = 3;
    localparam int TID_W    = 6;
    localparam int PRIO_W   = 5;
    localparam int REASON_W = 3;
    localparam int KIND_W   = 3;
    localparam int CODE_W   = 3;
    localparam int COUNT_W  = 5;

    localparam logic [ACTION_W-1:0] ACT_BLOCK    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ADJUST   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_WAKE_ONE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_WAKE_ALL = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_PEEK     = 3'd5;

    localparam logic [KIND_W-1:0] KIND_DONE      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WOKEN     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DUPLICATE = 3'd5;

    localparam logic [REASON_W-1:0] REASON_POST    = 3'd1;
    localparam logic [REASON_W-1:0] REASON_TIMEOUT = 3'd2;
    localparam logic [REASON_W-1:0] REASON_DESTROY = 3'd3;
    localparam logic [REASON_W-1:0] REASON_OWNER   = 3'd4;

    localparam logic [CODE_W-1:0] CODE_SUCCESS  = 3'd0;
    localparam logic [CODE_W-1:0] CODE_TIMEOUT  = 3'd1;
    localparam logic [CODE_W-1:0] CODE_DESTROY  = 3'd2;
    localparam logic [CODE_W-1:0] CODE_OWNER    = 3'd3;
    localparam logic [CODE_W-1:0] CODE_ABNORMAL = 3'd4;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_DELETE,
        CMD_POP
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REINS,
        ST_WAKE
    } state_t;

    function automatic logic [CODE_W-1:0] reason_to_code(input logic [REASON_W-1:0] reason);
        logic [CODE_W-1:0] code;
        unique case (reason)
            REASON_POST:    code = CODE_SUCCESS;
            REASON_TIMEOUT: code = CODE_TIMEOUT;
            REASON_DESTROY: code = CODE_DESTROY;
            REASON_OWNER:   code = CODE_OWNER;
            default:        code = CODE_ABNORMAL;
        endcase
        return code;
    endfunction

endpackage

FILE: rtl/pwq_cell.sv
module pwq_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pwq_pkg::cell_cmd_t        cmd,
    input  logic [pwq_pkg::TID_W-1:0] key_tid,
    input  logic [pwq_pkg::PRIO_W-1:0] key_prio,
    input  logic                      left_le,
    input  logic                      left_pre,
    input  logic                      left_valid,
    input  logic [pwq_pkg::TID_W-1:0] left_tid,
    input  logic [pwq_pkg::PRIO_W-1:0] left_prio,
    input  logic                      right_valid,
    input  logic [pwq_pkg::TID_W-1:0] right_tid,
    input  logic [pwq_pkg::PRIO_W-1:0] right_prio,
    output logic                      slot_valid,
    output logic [pwq_pkg::TID_W-1:0] slot_tid,
    output logic [pwq_pkg::PRIO_W-1:0] slot_prio,
    output logic                      le,
    output logic                      pre,
    output logic                      match
);
    import pwq_pkg::*;

    logic              valid_reg, valid_next;
    logic [TID_W-1:0]  tid_reg, tid_next;
    logic [PRIO_W-1:0] prio_reg, prio_next;

    assign match = valid_reg && (tid_reg == key_tid);
    assign le    = valid_reg && (prio_reg <= key_prio);
    // set on the matching cell and every cell behind it
    assign pre   = match || left_pre;

    always_comb
    begin
        valid_next = valid_reg;
        tid_next   = tid_reg;
        prio_next  = prio_reg;
        unique case (cmd)
            CMD_HOLD:
            begin
            end
            CMD_INSERT:
            begin
                if (!le)
                begin
                    if (left_le)
                    begin
                        valid_next = 1'b1;
                        tid_next   = key_tid;
                        prio_next  = key_prio;
                    end
                    else
                    begin
                        valid_next = left_valid;
                        tid_next   = left_tid;
                        prio_next  = left_prio;
                    end
                end
            end
            CMD_DELETE:
            begin
                if (pre)
                begin
                    valid_next = right_valid;
                    tid_next   = right_tid;
                    prio_next  = right_prio;
                end
            end
            CMD_POP:
            begin
                valid_next = right_valid;
                tid_next   = right_tid;
                prio_next  = right_prio;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tid_reg  <= tid_next;
        prio_reg <= prio_next;
    end

    assign slot_valid = valid_reg;
    assign slot_tid   = tid_reg;
    assign slot_prio  = prio_reg;

endmodule

FILE: rtl/priority_wait_queue.sv
// Flow: a taken start moves idle to exec; the result strobe is registered out of exec, or
// out of reins for adjust, which deletes in exec and reinserts in reins. Busy is high
// outside idle, so no new item is taken before the last one is through; wake all stays
// in wake and gives one result per cycle, one per woken task. Results are never held off.
// The cell row does a full insert, delete or head pop as one registered update.
// Reset (rst_n low, async) empties the queue and clears control state.
module priority_wait_queue #(
    parameter int MAX_WAITERS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [pwq_pkg::ACTION_W-1:0]  action,
    input  logic [pwq_pkg::TID_W-1:0]     task_id,
    input  logic [pwq_pkg::PRIO_W-1:0]    priority_req,
    input  logic [pwq_pkg::REASON_W-1:0]  wake_reason,
    output logic                          result_valid,
    output logic [pwq_pkg::KIND_W-1:0]    kind,
    output logic [pwq_pkg::TID_W-1:0]     out_task,
    output logic [pwq_pkg::PRIO_W-1:0]    out_priority,
    output logic [pwq_pkg::CODE_W-1:0]    wake_code,
    output logic [pwq_pkg::COUNT_W-1:0]   waiting_count,
    output logic                          last
);
    import pwq_pkg::*;

    localparam int N  = MAX_WAITERS;
    localparam int CW = $clog2(MAX_WAITERS + 1);

    state_t              state_reg, state_next;
    logic [ACTION_W-1:0] op_reg, op_next;
    logic [TID_W-1:0]    id_reg, id_next;
    logic [PRIO_W-1:0]   prio_reg, prio_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic [CW-1:0]       occ_reg, occ_next;

    logic                strobe_reg, strobe_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [TID_W-1:0]    otid_reg, otid_next;
    logic [PRIO_W-1:0]   oprio_reg, oprio_next;
    logic [CODE_W-1:0]   ocode_reg, ocode_next;
    logic [CW-1:0]       ocnt_reg, ocnt_next;
    logic                last_reg, last_next;

    cell_cmd_t           cmd;
    logic [N-1:0]        v, le, pre, match;
    logic [TID_W-1:0]    tid  [N];
    logic [PRIO_W-1:0]   prio [N];
    logic                any_match;
    logic [CW+COUNT_W-1:0] cnt_ext;

    assign any_match = |match;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic              l_le, l_pre, l_valid, r_valid;
        logic [TID_W-1:0]  l_tid, r_tid;
        logic [PRIO_W-1:0] l_prio, r_prio;

        if (i == 0)
        begin : g_head
            assign l_le    = 1'b1;
            assign l_pre   = 1'b0;
            assign l_valid = 1'b0;
            assign l_tid   = '0;
            assign l_prio  = '0;
        end
        else
        begin : g_mid
            assign l_le    = le[i-1];
            assign l_pre   = pre[i-1];
            assign l_valid = v[i-1];
            assign l_tid   = tid[i-1];
            assign l_prio  = prio[i-1];
        end

        if (i == N - 1)
        begin : g_tail
            assign r_valid = 1'b0;
            assign r_tid   = '0;
            assign r_prio  = '0;
        end
        else
        begin : g_body
            assign r_valid = v[i+1];
            assign r_tid   = tid[i+1];
            assign r_prio  = prio[i+1];
        end

        pwq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .key_tid     (id_reg),
            .key_prio    (prio_reg),
            .left_le     (l_le),
            .left_pre    (l_pre),
            .left_valid  (l_valid),
            .left_tid    (l_tid),
            .left_prio   (l_prio),
            .right_valid (r_valid),
            .right_tid   (r_tid),
            .right_prio  (r_prio),
            .slot_valid  (v[i]),
            .slot_tid    (tid[i]),
            .slot_prio   (prio[i]),
            .le          (le[i]),
            .pre         (pre[i]),
            .match       (match[i])
        );
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        id_next     = id_reg;
        prio_next   = prio_reg;
        code_next   = code_reg;
        occ_next    = occ_reg;
        cmd         = CMD_HOLD;
        strobe_next = 1'b0;
        kind_next   = KIND_DONE;
        otid_next   = '0;
        oprio_next  = '0;
        ocode_next  = '0;
        last_next   = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next     = action;
                    id_next     = task_id;
                    prio_next   = priority_req;
                    code_next   = reason_to_code(wake_reason);
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
                unique case (op_reg)
                    ACT_BLOCK:
                    begin
                        if (any_match)
                        begin
                            kind_next = KIND_DUPLICATE;
                        end
                        else if (occ_reg == CW'(MAX_WAITERS))
                        begin
                            kind_next = KIND_FULL;
                        end
                        else
                        begin
                            cmd      = CMD_INSERT;
                            occ_next = occ_reg + 1'b1;
                        end
                    end
                    ACT_REMOVE, ACT_ADJUST:
                    begin
                        if (!any_match)
                        begin
                            kind_next = KIND_NOT_FOUND;
                        end
                        else
                        begin
                            cmd      = CMD_DELETE;
                            occ_next = occ_reg - 1'b1;
                            if (op_reg == ACT_ADJUST)
                            begin
                                strobe_next = 1'b0;
                                state_next  = ST_REINS;
                            end
                        end
                    end
                    ACT_WAKE_ONE, ACT_WAKE_ALL:
                    begin
                        if (occ_reg == '0)
                        begin
                            kind_next = KIND_EMPTY;
                        end
                        else
                        begin
                            cmd        = CMD_POP;
                            occ_next   = occ_reg - 1'b1;
                            kind_next  = KIND_WOKEN;
                            otid_next  = tid[0];
                            oprio_next = prio[0];
                            ocode_next = code_reg;
                            last_next  = (op_reg == ACT_WAKE_ONE) || (occ_reg == CW'(1));
                            if (!last_next)
                            begin
                                state_next = ST_WAKE;
                            end
                        end
                    end
                    ACT_PEEK:
                    begin
                        if (occ_reg == '0)
                        begin
                            kind_next = KIND_EMPTY;
                        end
                        else
                        begin
                            otid_next  = tid[0];
                            oprio_next = prio[0];
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_REINS:
            begin
                cmd         = CMD_INSERT;
                occ_next    = occ_reg + 1'b1;
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_WAKE:
            begin
                cmd         = CMD_POP;
                occ_next    = occ_reg - 1'b1;
                strobe_next = 1'b1;
                kind_next   = KIND_WOKEN;
                otid_next   = tid[0];
                oprio_next  = prio[0];
                ocode_next  = code_reg;
                last_next   = (occ_reg == CW'(1));
                if (last_next)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        ocnt_next = occ_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            occ_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        id_reg    <= id_next;
        prio_reg  <= prio_next;
        code_reg  <= code_next;
        kind_reg  <= kind_next;
        otid_reg  <= otid_next;
        oprio_reg <= oprio_next;
        ocode_reg <= ocode_next;
        ocnt_reg  <= ocnt_next;
        last_reg  <= last_next;
    end

    assign cnt_ext       = {{COUNT_W{1'b0}}, ocnt_reg};
    assign busy          = (state_reg != ST_IDLE);
    assign result_valid  = strobe_reg;
    assign kind          = kind_reg;
    assign out_task      = otid_reg;
    assign out_priority  = oprio_reg;
    assign wake_code     = ocode_reg;
    assign waiting_count = cnt_ext[COUNT_W-1:0];
    assign last          = last_reg;

endmodule
